[rtl/core/yuyv2rgb_pkg.sv]
// Shared types, coefficients and pipeline control for the YUYV to RGBA converter.
package yuyv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TERM_W    = 25;   // holds any coefficient times centred chroma
    localparam int SUM_W     = TERM_W + 1;

    // unsigned Q1.16 coefficients, held as signed so products stay signed
    localparam logic signed [17:0] COEF_R_CR = 18'sd92176;
    localparam logic signed [17:0] COEF_G_CB = 18'sd22643;
    localparam logic signed [17:0] COEF_G_CR = 18'sd46983;
    localparam logic signed [17:0] COEF_B_CB = 18'sd116589;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef logic signed [7:0]        t_chroma;
    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        logic [7:0] first_luma;
        logic [7:0] blue_chroma;
        logic [7:0] second_luma;
        logic [7:0] red_chroma;
        logic       frame_end_in;
    } t_yuyv_item;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic       alpha_level;
        logic       frame_end_out;
    } t_rgba_item;

    // per-stage load enables
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctl;

    typedef struct packed {
        t_term red;
        t_term green;   // amount to subtract from luma
        t_term blue;
    } t_chroma_terms;

endpackage

[rtl/core/yuyv2rgb_intf.sv]
// Valid/ready channel interfaces for macropixels in and RGBA pairs out.
interface yuyv2rgb_yuyv_if
    import yuyv2rgb_pkg::*;
;
    logic       valid;
    logic       ready;
    t_yuyv_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface yuyv2rgb_rgba_if
    import yuyv2rgb_pkg::*;
;
    logic       valid;
    logic       ready;
    t_rgba_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/yuyv_to_rgba_converter.sv]
// Top level: YUYV macropixel to RGBA pixel pair converter, four-stage pipeline.
// Takes one YUYV macropixel per clock while the input is ready, and presents
// the two RGBA pixels of each macropixel from the output register after it
// has passed all stages. Four register stages (chroma centring, coefficient
// multiply, green term sum, luma add with clamp) each carry a valid bit; the
// last stage is the output register. A stall on the output backs up through a
// combinational ready chain, and an empty stage is filled even while later
// stages wait, so the block holds up to four items. With the output always
// ready the throughput is one item per cycle. Alpha is the constant 1 and the
// end-of-frame flag travels with its macropixel.
module yuyv_to_rgba_converter
    import yuyv2rgb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    yuyv2rgb_yuyv_if.sink          i_yuyv,
    yuyv2rgb_rgba_if.source        o_rgba
);

    logic [3:0]    r_valid;
    logic [3:0]    n_valid;
    logic [3:0]    stage_rdy;
    t_pipe_ctl     ctl;
    t_chroma_terms terms;
    logic [7:0]    luma0, luma1;
    logic          fe_s3;
    logic          r_frame_end;

    // a stage may load when it is empty or its content moves on this cycle
    assign stage_rdy[3] = !r_valid[3] || o_rgba.ready;
    assign stage_rdy[2] = !r_valid[2] || stage_rdy[3];
    assign stage_rdy[1] = !r_valid[1] || stage_rdy[2];
    assign stage_rdy[0] = !r_valid[0] || stage_rdy[1];

    assign ctl.en1 = stage_rdy[0] && i_yuyv.valid;
    assign ctl.en2 = stage_rdy[1] && r_valid[0];
    assign ctl.en3 = stage_rdy[2] && r_valid[1];
    assign ctl.en4 = stage_rdy[3] && r_valid[2];

    always_comb begin
        n_valid = r_valid;
        if (stage_rdy[0]) n_valid[0] = i_yuyv.valid;
        if (stage_rdy[1]) n_valid[1] = r_valid[0];
        if (stage_rdy[2]) n_valid[2] = r_valid[1];
        if (stage_rdy[3]) n_valid[3] = r_valid[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en4) begin
            r_frame_end <= fe_s3;
        end
    end

    yuyv2rgb_chroma u_chroma (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_item        (i_yuyv.payload),
        .o_terms       (terms),
        .o_first_luma  (luma0),
        .o_second_luma (luma1),
        .o_frame_end   (fe_s3)
    );

    yuyv2rgb_pixel u_pixel0 (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_luma  (luma0),
        .i_terms (terms),
        .o_red   (o_rgba.payload.first_red),
        .o_green (o_rgba.payload.first_green),
        .o_blue  (o_rgba.payload.first_blue)
    );

    yuyv2rgb_pixel u_pixel1 (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_luma  (luma1),
        .i_terms (terms),
        .o_red   (o_rgba.payload.second_red),
        .o_green (o_rgba.payload.second_green),
        .o_blue  (o_rgba.payload.second_blue)
    );

    assign i_yuyv.ready                = stage_rdy[0];
    assign o_rgba.valid                = r_valid[3];
    assign o_rgba.payload.alpha_level   = 1'b1;
    assign o_rgba.payload.frame_end_out = r_frame_end;

endmodule

[rtl/core/yuyv2rgb_chroma.sv]
// Stages 1-3: centre chroma, multiply by the coefficients, combine green terms.
module yuyv2rgb_chroma
    import yuyv2rgb_pkg::*;
(
    input  logic          i_clk,
    input  t_pipe_ctl     i_ctl,
    input  t_yuyv_item    i_item,
    output t_chroma_terms o_terms,
    output logic [7:0]    o_first_luma,
    output logic [7:0]    o_second_luma,
    output logic          o_frame_end
);

    // stage 1
    t_chroma    r_cb_c, r_cr_c;
    logic [7:0] r_y0_s1, r_y1_s1;
    logic       r_fe_s1;

    // stage 2
    t_term      r_p_rcr, r_p_gcb, r_p_gcr, r_p_bcb;
    logic [7:0] r_y0_s2, r_y1_s2;
    logic       r_fe_s2;

    // stage 3
    t_chroma_terms r_terms;
    logic [7:0]    r_y0_s3, r_y1_s3;
    logic          r_fe_s3;

    logic signed [25:0]     n_p_rcr, n_p_gcb, n_p_gcr, n_p_bcb;
    logic signed [TERM_W:0] n_g_sum;

    // products fit in TERM_W bits: |coef * 128| < 2^24
    assign n_p_rcr = r_cr_c * COEF_R_CR;
    assign n_p_gcb = r_cb_c * COEF_G_CB;
    assign n_p_gcr = r_cr_c * COEF_G_CR;
    assign n_p_bcb = r_cb_c * COEF_B_CB;
    assign n_g_sum = {r_p_gcb[TERM_W-1], r_p_gcb} + {r_p_gcr[TERM_W-1], r_p_gcr};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            // offset binary minus 128 is the MSB flipped
            r_cb_c  <= t_chroma'({~i_item.blue_chroma[7], i_item.blue_chroma[6:0]});
            r_cr_c  <= t_chroma'({~i_item.red_chroma[7], i_item.red_chroma[6:0]});
            r_y0_s1 <= i_item.first_luma;
            r_y1_s1 <= i_item.second_luma;
            r_fe_s1 <= i_item.frame_end_in;
        end
        if (i_ctl.en2) begin
            r_p_rcr <= n_p_rcr[TERM_W-1:0];
            r_p_gcb <= n_p_gcb[TERM_W-1:0];
            r_p_gcr <= n_p_gcr[TERM_W-1:0];
            r_p_bcb <= n_p_bcb[TERM_W-1:0];
            r_y0_s2 <= r_y0_s1;
            r_y1_s2 <= r_y1_s1;
            r_fe_s2 <= r_fe_s1;
        end
        if (i_ctl.en3) begin
            r_terms.red   <= r_p_rcr;
            r_terms.green <= n_g_sum[TERM_W-1:0];
            r_terms.blue  <= r_p_bcb;
            r_y0_s3       <= r_y0_s2;
            r_y1_s3       <= r_y1_s2;
            r_fe_s3       <= r_fe_s2;
        end
    end

    assign o_terms       = r_terms;
    assign o_first_luma  = r_y0_s3;
    assign o_second_luma = r_y1_s3;
    assign o_frame_end   = r_fe_s3;

endmodule

[rtl/core/yuyv2rgb_pixel.sv]
// Stage 4, one pixel: luma plus red/blue, minus green, floor and clamp to 0..255.
module yuyv2rgb_pixel
    import yuyv2rgb_pkg::*;
(
    input  logic          i_clk,
    input  t_pipe_ctl     i_ctl,
    input  logic [7:0]    i_luma,
    input  t_chroma_terms i_terms,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue
);

    logic signed [SUM_W-1:0] n_base, n_sum_r, n_sum_g, n_sum_b;
    logic [7:0]              r_red, r_green, r_blue;

    function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

    assign n_base  = {2'b00, i_luma, {FRAC_BITS{1'b0}}};
    assign n_sum_r = n_base + {i_terms.red[TERM_W-1], i_terms.red};
    assign n_sum_g = n_base - {i_terms.green[TERM_W-1], i_terms.green};
    assign n_sum_b = n_base + {i_terms.blue[TERM_W-1], i_terms.blue};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_red   <= clamp_chan(n_sum_r);
            r_green <= clamp_chan(n_sum_g);
            r_blue  <= clamp_chan(n_sum_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

[rtl/core/yuyv2rgb_checker.sv]
// Port-level checks for the YUYV to RGBA converter, bound to the top level.
module yuyv2rgb_checker
    import yuyv2rgb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_rgba_item i_out_payload
);

    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_count = r_count;
        if (in_xfer && !out_xfer) n_count = r_count + 3'd1;
        if (!in_xfer && out_xfer) n_count = r_count - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // never more than four items in flight
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("more than four items in flight");

    // nothing comes out that was not taken in
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 3'd0)
        else $error("output valid with no item in flight");

    // a ready output lets the whole pipe move
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input not ready while output ready");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_payload.alpha_level)
        else $error("alpha not 1");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled output changed");

endmodule

bind yuyv_to_rgba_converter yuyv2rgb_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_yuyv.valid),
    .i_in_ready    (i_yuyv.ready),
    .i_out_valid   (o_rgba.valid),
    .i_out_ready   (o_rgba.ready),
    .i_out_payload (o_rgba.payload)
);
